/* hw/rtl/scvs_pkg.sv */
// Package: shared types, operation and status codes for the scoped variable store.
`default_nettype none

package scvs_pkg;

    localparam int NAME_W        = 16;
    localparam int VALUE_W       = 64;
    localparam int LEVEL_OUT_W   = 4;

    localparam int ENTRIES_DEF   = 64;
    localparam int LEVELS_DEF    = 16;
    localparam int NAME_BITS_DEF = 16;

    // operation codes on the func field; 6 and 7 are no-ops
    localparam logic [2:0] FN_DECLARE = 3'd0;
    localparam logic [2:0] FN_SET     = 3'd1;
    localparam logic [2:0] FN_GET     = 3'd2;
    localparam logic [2:0] FN_IS_CONST = 3'd3;
    localparam logic [2:0] FN_ENTER   = 3'd4;
    localparam logic [2:0] FN_LEAVE   = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_CONST     = 3'd2;
    localparam logic [2:0] ST_BASE      = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_LEVELS    = 3'd5;

    typedef struct packed {
        logic [2:0]         func;
        logic [NAME_W-1:0]  name_id;
        logic [VALUE_W-1:0] write_value;
        logic               const_flag;
    } in_item_t;

    typedef struct packed {
        logic                   success;
        logic [VALUE_W-1:0]     read_value;
        logic                   is_constant;
        logic [2:0]             status;
        logic [LEVEL_OUT_W-1:0] scope_level;
    } out_item_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic               match_en;
        logic               push;
        logic               set_sel;
        logic               set_lvl;
        logic               cflag;
        logic [VALUE_W-1:0] value;
    } cell_ctl_t;

    // what the row of cells reports back
    typedef struct packed {
        logic               found;
        logic               lvl_found;
        logic               pop_any;
        logic               is_const;
        logic [VALUE_W-1:0] value;
    } chain_res_t;

endpackage

`default_nettype wire

/* hw/rtl/scvs_cell.sv */
// One stack entry: stored fields, registered compare flags and chain links.
`default_nettype none

module scvs_cell
    import scvs_pkg::*;
#(
    parameter int IDX = 0,
    parameter int NW  = 16,
    parameter int LW  = 4,
    parameter int CW  = 7
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cell_ctl_t          ctl,
    input  wire logic [NW-1:0]      key_name,
    input  wire logic [LW-1:0]      key_level,
    input  wire logic [CW-1:0]      count,
    input  wire logic               hit_above,
    input  wire logic               pop_below,
    output logic                    hit,
    output logic                    pop,
    output logic                    boundary,
    output logic                    lvl_term,
    output logic                    const_term,
    output logic [VALUE_W-1:0]      val_term
);

    logic [NW-1:0]      name_reg;
    logic [LW-1:0]      level_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               const_reg;
    logic               name_hit_reg;
    logic               lvl_hit_reg;

    logic               live;
    logic               sel;
    logic               push_here;
    logic               wr_val;
    logic               wr_const;

    assign live      = CW'(IDX) < count;
    assign sel       = name_hit_reg & ~hit_above;
    assign hit       = hit_above | name_hit_reg;
    assign pop       = lvl_hit_reg;
    assign boundary  = lvl_hit_reg & ~pop_below;
    assign lvl_term  = name_hit_reg & lvl_hit_reg;
    assign val_term  = sel ? value_reg : '0;
    assign const_term = sel & const_reg;

    assign push_here = ctl.push && (count == CW'(IDX));
    assign wr_val    = push_here | (ctl.set_sel & sel) | (ctl.set_lvl & lvl_term);
    assign wr_const  = push_here | (ctl.set_lvl & lvl_term);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_hit_reg <= 1'b0;
            lvl_hit_reg  <= 1'b0;
        end
        else if (ctl.match_en)
        begin
            name_hit_reg <= live && (name_reg == key_name);
            lvl_hit_reg  <= live && (level_reg == key_level);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_here)
        begin
            name_reg  <= key_name;
            level_reg <= key_level;
        end
        if (wr_val)
            value_reg <= ctl.value;
        if (wr_const)
            const_reg <= ctl.cflag;
    end

endmodule

`default_nettype wire

/* hw/rtl/scvs_chain.sv */
// Row of entry cells with the priority chain and result gathering.
`default_nettype none

module scvs_chain
    import scvs_pkg::*;
#(
    parameter int MAX_ENTRIES = ENTRIES_DEF,
    parameter int NW          = 16,
    parameter int LW          = 4,
    parameter int CW          = 7
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cell_ctl_t     ctl,
    input  wire logic [NW-1:0] key_name,
    input  wire logic [LW-1:0] key_level,
    input  wire logic [CW-1:0] count,
    output chain_res_t         res,
    output logic [CW-1:0]      pop_base
);

    // hit runs from the top of the stack down, pop from the bottom up
    logic [MAX_ENTRIES:0]   hit_link;
    logic [MAX_ENTRIES:0]   pop_link;
    logic [MAX_ENTRIES-1:0] bnd;
    logic [MAX_ENTRIES-1:0] lvl_t;
    logic [MAX_ENTRIES-1:0] const_t;
    logic [VALUE_W-1:0]     val_t [MAX_ENTRIES];

    assign hit_link[MAX_ENTRIES] = 1'b0;
    assign pop_link[0]           = 1'b0;

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        scvs_cell #(
            .IDX (i),
            .NW  (NW),
            .LW  (LW),
            .CW  (CW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .key_name   (key_name),
            .key_level  (key_level),
            .count      (count),
            .hit_above  (hit_link[i+1]),
            .pop_below  (pop_link[i]),
            .hit        (hit_link[i]),
            .pop        (pop_link[i+1]),
            .boundary   (bnd[i]),
            .lvl_term   (lvl_t[i]),
            .const_term (const_t[i]),
            .val_term   (val_t[i])
        );
    end

    always_comb
    begin
        logic [VALUE_W-1:0] v;
        logic [CW-1:0]      b;
        v = '0;
        b = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            v = v | val_t[i];
            b = b | (bnd[i] ? CW'(i) : '0);
        end
        res.value     = v;
        pop_base      = b;
        res.found     = hit_link[0];
        res.lvl_found = |lvl_t;
        res.pop_any   = |bnd;
        res.is_const  = |const_t;
    end

endmodule

`default_nettype wire

/* hw/rtl/scoped_variable_store_core.sv */
// Top level: operation sequencer, scope/count registers and result register.
//
//  channel | direction | payload    | handshake
//  --------+-----------+------------+--------------------
//  in      | input     | in_item_t  | in_valid / in_ready
//  out     | output    | out_item_t | out_valid / out_ready
//
// A compare step has all cells compare name and level into their match
// flags; an execute step runs the priority chain, the write-back and the
// result register and can already accept the next item.
// Reset zeroes the entry count and scope level; entries need no clearing.
// A stalled result holds the result register and the execute step waits.
`default_nettype none

module scoped_variable_store_core
    import scvs_pkg::*;
#(
    parameter int MAX_ENTRIES = ENTRIES_DEF,
    parameter int MAX_LEVELS  = LEVELS_DEF,
    parameter int NAME_BITS   = NAME_BITS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    localparam int NW = (NAME_BITS < NAME_W) ? NAME_BITS : NAME_W;
    localparam int LW = $clog2(MAX_LEVELS);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MATCH = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    in_item_t        op_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic [LW-1:0]   level_reg, level_next;
    logic            out_valid_reg;
    out_item_t       out_reg, out_next;

    cell_ctl_t       ctl;
    chain_res_t      res;
    logic [CW-1:0]   pop_base;
    logic            exec_go;
    logic            accept;
    logic [LW+LEVEL_OUT_W-1:0] lvl_ext;

    assign exec_go   = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == S_IDLE) || exec_go;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    scvs_chain #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .NW          (NW),
        .LW          (LW),
        .CW          (CW)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .key_name  (op_reg.name_id[NW-1:0]),
        .key_level (level_reg),
        .count     (count_reg),
        .res       (res),
        .pop_base  (pop_base)
    );

    always_comb
    begin
        ctl          = '0;
        ctl.match_en = (state_reg == S_MATCH);
        ctl.cflag    = op_reg.const_flag;
        ctl.value    = op_reg.write_value;
        count_next   = count_reg;
        level_next   = level_reg;
        out_next     = '0;
        out_next.status = ST_OK;

        case (op_reg.func)
            FN_DECLARE:
            begin
                if (res.lvl_found)
                begin
                    ctl.set_lvl          = exec_go;
                    out_next.success     = 1'b1;
                    out_next.is_constant = op_reg.const_flag;
                end
                else if (count_reg == CW'(MAX_ENTRIES))
                    out_next.status = ST_FULL;
                else
                begin
                    ctl.push             = exec_go;
                    count_next           = count_reg + 1'b1;
                    out_next.success     = 1'b1;
                    out_next.is_constant = op_reg.const_flag;
                end
            end
            FN_SET:
            begin
                if (!res.found)
                    out_next.status = ST_NOT_FOUND;
                else if (res.is_const)
                begin
                    out_next.is_constant = 1'b1;
                    out_next.status      = ST_CONST;
                end
                else
                begin
                    ctl.set_sel      = exec_go;
                    out_next.success = 1'b1;
                end
            end
            FN_GET, FN_IS_CONST:
            begin
                if (!res.found)
                    out_next.status = ST_NOT_FOUND;
                else
                begin
                    out_next.success     = 1'b1;
                    out_next.is_constant = res.is_const;
                    if (op_reg.func == FN_GET)
                        out_next.read_value = res.value;
                end
            end
            FN_ENTER:
            begin
                if (level_reg == LW'(MAX_LEVELS - 1))
                    out_next.status = ST_LEVELS;
                else
                begin
                    level_next       = level_reg + 1'b1;
                    out_next.success = 1'b1;
                end
            end
            FN_LEAVE:
            begin
                if (level_reg == '0)
                    out_next.status = ST_BASE;
                else
                begin
                    if (res.pop_any)
                        count_next = pop_base;
                    level_next       = level_reg - 1'b1;
                    out_next.success = 1'b1;
                end
            end
            default:
            begin
                out_next = '0;
            end
        endcase

        lvl_ext              = {{LEVEL_OUT_W{1'b0}}, level_next};
        out_next.scope_level = lvl_ext[LEVEL_OUT_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_MATCH;
            S_MATCH: state_next = S_EXEC;
            S_EXEC:
            begin
                if (exec_go)
                    state_next = accept ? S_MATCH : S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_go)
            begin
                count_reg     <= count_next;
                level_reg     <= level_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            op_reg <= in_data;
        if (exec_go)
            out_reg <= out_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count above capacity");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LW'(MAX_LEVELS - 1))
        else $error("scope level above limit");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result appeared without an execute step");

    a_no_accept_in_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MATCH) |-> !in_ready)
        else $error("transaction accepted during compare");

    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.success) |-> (out_reg.status == ST_OK))
        else $error("success reported with error status");

endmodule

`default_nettype wire
